/* rtl/qpf_pkg.sv */
package qpf_pkg;

    localparam int CHAR_W  = 8;
    localparam int COL_W   = 11;
    localparam int CFG_IDX_W = 2;

    localparam logic [CHAR_W-1:0] ESCAPE_BYTE = 8'h5C;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_QUOTE_CHAR    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CURSOR_COLUMN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INNER_MODE    = 2'd2;

    localparam logic [CHAR_W-1:0] QUOTE_CHAR_RST    = 8'd34;
    localparam logic [COL_W-1:0]  CURSOR_COLUMN_RST = 11'd1;
    localparam logic              INNER_MODE_RST    = 1'b0;

    localparam logic STATUS_FOUND     = 1'b0;
    localparam logic STATUS_NOT_FOUND = 1'b1;

    typedef struct packed {
        logic [CHAR_W-1:0] char_code;
        logic              line_end;
    } t_in_word;

    typedef struct packed {
        logic             status;
        logic [COL_W-1:0] start_column;
        logic [COL_W-1:0] end_column;
    } t_out_word;

    typedef struct packed {
        logic [CHAR_W-1:0] quote_char;
        logic [COL_W-1:0]  cursor_column;
        logic              inner_mode;
    } t_cfg;

endpackage

/* rtl/qpf_if.sv */
interface qpf_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* rtl/quote_pair_finder.sv */
// channel  | dir | word                                  | handshake
// i_in     | in  | char_code[7:0], line_end              | valid/ready
// o_out    | out | status, start_column[10:0], end_column[10:0] | valid/ready
// i_cfg_*  | in  | index[1:0], data[10:0]                | write enable only
//
// One character word per cycle, set by the single scan stage between the input
// register and the result register. The result is loaded into the result register
// as the line-end word leaves the scan stage. Reset is synchronous and clears the
// line state and the configuration to defaults. A full result register stalls
// only a line-end word; other characters keep flowing.
module quote_pair_finder #(
    parameter int MAX_LINE = 1024
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    qpf_if.sink                            i_in,
    qpf_if.source                          o_out,
    input  logic                           i_cfg_we,
    input  logic [qpf_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [qpf_pkg::COL_W-1:0]      i_cfg_data
);

    qpf_pkg::t_cfg      cfg;
    logic               out_free;
    logic               res_valid;
    qpf_pkg::t_out_word res_data;

    qpf_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    qpf_scan #(
        .MAX_LINE (MAX_LINE)
    ) u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cfg       (cfg),
        .i_out_free  (out_free),
        .o_res_valid (res_valid),
        .o_res_data  (res_data)
    );

    qpf_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (res_valid),
        .i_data  (res_data),
        .o_free  (out_free),
        .o_out   (o_out)
    );

endmodule

/* rtl/qpf_cfg.sv */
module qpf_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [qpf_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [qpf_pkg::COL_W-1:0]      i_cfg_data,
    output qpf_pkg::t_cfg                  o_cfg
);

    qpf_pkg::t_cfg r_cfg;
    qpf_pkg::t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_index)
                qpf_pkg::CFG_QUOTE_CHAR: begin
                    n_cfg.quote_char = i_cfg_data[qpf_pkg::CHAR_W-1:0];
                end
                qpf_pkg::CFG_CURSOR_COLUMN: begin
                    n_cfg.cursor_column = i_cfg_data;
                end
                qpf_pkg::CFG_INNER_MODE: begin
                    n_cfg.inner_mode = i_cfg_data[0];
                end
                default: begin
                    // drop writes beyond the register list
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.quote_char    <= qpf_pkg::QUOTE_CHAR_RST;
            r_cfg.cursor_column <= qpf_pkg::CURSOR_COLUMN_RST;
            r_cfg.inner_mode    <= qpf_pkg::INNER_MODE_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

/* rtl/qpf_scan.sv */
module qpf_scan #(
    parameter int MAX_LINE = 1024
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    qpf_if.sink                   i_in,
    input  qpf_pkg::t_cfg         i_cfg,
    input  logic                  i_out_free,
    output logic                  o_res_valid,
    output qpf_pkg::t_out_word    o_res_data
);

    localparam int PW = $clog2(MAX_LINE + 1);
    localparam int IW = $clog2(MAX_LINE);
    localparam int CW = (PW > qpf_pkg::COL_W) ? PW : qpf_pkg::COL_W;
    localparam int RW = ((IW + 2) > qpf_pkg::COL_W) ? (IW + 2) : qpf_pkg::COL_W;

    logic               r_in_valid;
    qpf_pkg::t_in_word  r_in_data;

    logic [PW-1:0] r_pos,        n_pos;
    logic          r_skip,       n_skip;
    logic          r_inside,     n_inside;
    logic [IW-1:0] r_open_pos,   n_open_pos;
    logic          r_found,      n_found;
    logic [IW-1:0] r_found_open, n_found_open;
    logic [IW-1:0] r_found_close, n_found_close;

    logic          en;
    logic          last;
    logic [IW-1:0] idx;
    logic [RW-1:0] sc;
    logic [RW-1:0] ec;

    // a line-end word needs a free output slot, any other word goes straight through
    assign last = r_in_data.line_end;
    assign en = r_in_valid && (!last || i_out_free);
    assign i_in.ready = !r_in_valid || en;
    assign idx = r_pos[IW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in_data <= i_in.data;
        end
    end

    always_comb begin
        n_pos         = r_pos;
        n_skip        = r_skip;
        n_inside      = r_inside;
        n_open_pos    = r_open_pos;
        n_found       = r_found;
        n_found_open  = r_found_open;
        n_found_close = r_found_close;
        if (r_pos < PW'(MAX_LINE)) begin
            n_pos = r_pos + PW'(1);
            if (!r_found) begin
                if (r_skip) begin
                    n_skip = 1'b0;
                end else if (r_in_data.char_code == qpf_pkg::ESCAPE_BYTE && !last) begin
                    n_skip = 1'b1;
                end else if (r_in_data.char_code == i_cfg.quote_char) begin
                    if (!r_inside) begin
                        n_inside   = 1'b1;
                        n_open_pos = idx;
                    end else begin
                        n_inside = 1'b0;
                        if (CW'(i_cfg.cursor_column) <= CW'(idx) + CW'(1)) begin
                            n_found       = 1'b1;
                            n_found_open  = r_open_pos;
                            n_found_close = idx;
                        end
                    end
                end
            end
        end
    end

    always_comb begin
        if (i_cfg.inner_mode) begin
            sc = RW'(n_found_open) + RW'(2);
            ec = RW'(n_found_close);
            if (sc > ec) begin
                ec = sc - RW'(1);
            end
        end else begin
            sc = RW'(n_found_open) + RW'(1);
            ec = RW'(n_found_close) + RW'(1);
        end
    end

    assign o_res_valid = en && last;

    always_comb begin
        if (n_found) begin
            o_res_data.status       = qpf_pkg::STATUS_FOUND;
            o_res_data.start_column = sc[qpf_pkg::COL_W-1:0];
            o_res_data.end_column   = ec[qpf_pkg::COL_W-1:0];
        end else begin
            o_res_data.status       = qpf_pkg::STATUS_NOT_FOUND;
            o_res_data.start_column = '0;
            o_res_data.end_column   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (en && last)) begin
            r_pos         <= '0;
            r_skip        <= 1'b0;
            r_inside      <= 1'b0;
            r_open_pos    <= '0;
            r_found       <= 1'b0;
            r_found_open  <= '0;
            r_found_close <= '0;
        end else if (en) begin
            r_pos         <= n_pos;
            r_skip        <= n_skip;
            r_inside      <= n_inside;
            r_open_pos    <= n_open_pos;
            r_found       <= n_found;
            r_found_open  <= n_found_open;
            r_found_close <= n_found_close;
        end
    end

    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= PW'(MAX_LINE))
        else $error("scan position ran past the line limit");

    a_line_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (en && last) |=> (r_pos == '0 && !r_found && !r_inside && !r_skip))
        else $error("line state not cleared after line end");

    a_found_closed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_found |-> (!r_inside && r_found_open < r_found_close))
        else $error("chosen pair is not a closed pair");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !en) |=> (r_in_valid && $stable(r_in_data) && $stable(r_pos)))
        else $error("stalled line-end word lost or state moved");

endmodule

/* rtl/qpf_out_reg.sv */
module qpf_out_reg (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  qpf_pkg::t_out_word  i_data,
    output logic                o_free,
    qpf_if.source               o_out
);

    logic               r_valid;
    logic               n_valid;
    qpf_pkg::t_out_word r_data;

    assign o_free  = !r_valid || o_out.ready;
    assign n_valid = (r_valid && !o_out.ready) || i_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data <= i_data;
        end
    end

    assign o_out.valid = r_valid;
    assign o_out.data  = r_data;

endmodule
